/* rtl/core/morse_pkg.sv */
// Package for the Morse character encoder: symbol codes, code-table types
// and the character lookup function. No dependencies.
`default_nettype none

package morse_pkg;

   localparam int unsigned MaxElems = 7;
   localparam int unsigned LenWidth = 3;
   localparam int unsigned SymWidth = 2;

   typedef enum logic [SymWidth-1:0] {
      SYM_DOT  = 2'd0,
      SYM_DASH = 2'd1,
      SYM_GAP  = 2'd2,
      SYM_END  = 2'd3
   } symbol_type;

   typedef enum logic [1:0] {
      KIND_MARK,
      KIND_SPACE,
      KIND_UNKNOWN
   } kind_type;

   // pat holds the elements as written, right aligned, 1 = dash
   typedef struct packed {
      kind_type              kind;
      logic [LenWidth-1:0]   len;
      logic [MaxElems-1:0]   pat;
   } code_type;

   function automatic code_type mark(input logic [LenWidth-1:0] n,
                                     input logic [MaxElems-1:0] p);
      code_type c;
      c.kind = KIND_MARK;
      c.len  = n;
      c.pat  = p;
      return c;
   endfunction

   function automatic code_type code_lookup(input logic [7:0] ch);
      code_type c;
      c.kind = KIND_UNKNOWN;
      c.len  = 3'd3;
      c.pat  = '0;
      case (ch)
         "0":  c = mark(3'd5, 7'b11111);
         "1":  c = mark(3'd5, 7'b01111);
         "2":  c = mark(3'd5, 7'b00111);
         "3":  c = mark(3'd5, 7'b00011);
         "4":  c = mark(3'd5, 7'b00001);
         "5":  c = mark(3'd5, 7'b00000);
         "6":  c = mark(3'd5, 7'b10000);
         "7":  c = mark(3'd5, 7'b11000);
         "8":  c = mark(3'd5, 7'b11100);
         "9":  c = mark(3'd5, 7'b11110);
         "A":  c = mark(3'd2, 7'b01);
         "B":  c = mark(3'd4, 7'b1000);
         "C":  c = mark(3'd4, 7'b1010);
         "D":  c = mark(3'd3, 7'b100);
         "E":  c = mark(3'd1, 7'b0);
         "F":  c = mark(3'd4, 7'b0010);
         "G":  c = mark(3'd3, 7'b110);
         "H":  c = mark(3'd4, 7'b0000);
         "I":  c = mark(3'd2, 7'b00);
         "J":  c = mark(3'd4, 7'b0111);
         "K":  c = mark(3'd3, 7'b101);
         "L":  c = mark(3'd4, 7'b0100);
         "M":  c = mark(3'd2, 7'b11);
         "N":  c = mark(3'd2, 7'b10);
         "O":  c = mark(3'd3, 7'b111);
         "P":  c = mark(3'd4, 7'b0110);
         "Q":  c = mark(3'd4, 7'b1101);
         "R":  c = mark(3'd3, 7'b010);
         "S":  c = mark(3'd3, 7'b000);
         "T":  c = mark(3'd1, 7'b1);
         "U":  c = mark(3'd3, 7'b001);
         "V":  c = mark(3'd4, 7'b0001);
         "W":  c = mark(3'd3, 7'b011);
         "X":  c = mark(3'd4, 7'b1001);
         "Y":  c = mark(3'd4, 7'b1011);
         "Z":  c = mark(3'd4, 7'b1100);
         ".":  c = mark(3'd6, 7'b010101);
         ",":  c = mark(3'd6, 7'b110011);
         "?":  c = mark(3'd6, 7'b001100);
         "'":  c = mark(3'd6, 7'b011110);
         "!":  c = mark(3'd6, 7'b101011);
         "/":  c = mark(3'd5, 7'b10010);
         "(":  c = mark(3'd5, 7'b10110);
         ")":  c = mark(3'd6, 7'b101101);
         "&":  c = mark(3'd5, 7'b01000);
         ":":  c = mark(3'd6, 7'b111000);
         ";":  c = mark(3'd6, 7'b101010);
         "=":  c = mark(3'd5, 7'b10001);
         "+":  c = mark(3'd5, 7'b01010);
         "-":  c = mark(3'd6, 7'b100001);
         "_":  c = mark(3'd6, 7'b001101);
         "\"": c = mark(3'd6, 7'b010010);
         "$":  c = mark(3'd7, 7'b0001001);
         "@":  c = mark(3'd6, 7'b011010);
         " ": begin
            c.kind = KIND_SPACE;
            c.len  = 3'd1;
            c.pat  = '0;
         end
         default: begin
            c.kind = KIND_UNKNOWN;
            c.len  = 3'd3;
            c.pat  = '0;
         end
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/morse_character_encoder_core.sv */
// Morse character encoder top level: accepts ASCII characters and emits
// their Morse symbols one beat at a time. Uses morse_pkg and morse_lut.
//
// Usage:
//  - req channel: one 8-bit ASCII character per beat. Lower case is folded.
//  - rsp channel: one symbol per beat (dot, dash, word gap, letter end);
//    rsp_last is high on the letter end that closes each character.
//  - A character with n elements (1 to 7) yields n + 1 beats. The looked-up
//    code is loaded into a 2-bit-per-element shift register and one element
//    leaves per cycle while the receiver does not stall.
//  - The first symbol goes from the shift register into the output register.
//  - One character at a time: req_ready is low from acceptance until the
//    letter end has been registered on the output.
//  - Receiver stall: the output register holds its beat and the shifter
//    waits; nothing is lost or repeated.
//  - Reset (synchronous): clears the busy flag and the output valid.
`default_nettype none

module morse_character_encoder_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_character,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [1:0]      rsp_symbol,
   output logic            rsp_last
);

   localparam int unsigned RowWidth = morse_pkg::MaxElems * morse_pkg::SymWidth;

   logic [morse_pkg::LenWidth-1:0] lut_len;
   logic [RowWidth-1:0]            lut_syms;

   logic                           busy_ff, busy_in;
   logic [morse_pkg::LenWidth-1:0] cnt_ff, cnt_in;
   logic [RowWidth-1:0]            sym_ff, sym_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [1:0]                     rsp_symbol_ff, rsp_symbol_in;
   logic                           rsp_last_ff, rsp_last_in;
   logic                           step;

   morse_lut u_lut (
      .character (req_character),
      .len       (lut_len),
      .syms      (lut_syms)
   );

   assign req_ready  = !busy_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_symbol = rsp_symbol_ff;
   assign rsp_last   = rsp_last_ff;

   assign step = busy_ff && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      busy_in       = busy_ff;
      cnt_in        = cnt_ff;
      sym_in        = sym_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_last_in   = rsp_last_ff;

      if (req_valid && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = lut_len;
         sym_in  = lut_syms;
      end

      if (step) begin
         rsp_valid_in = 1'b1;
         if (cnt_ff != '0) begin
            rsp_symbol_in = sym_ff[1:0];
            rsp_last_in   = 1'b0;
            sym_in        = sym_ff >> morse_pkg::SymWidth;
            cnt_in        = cnt_ff - 3'd1;
         end else begin
            rsp_symbol_in = morse_pkg::SYM_END;
            rsp_last_in   = 1'b1;
            busy_in       = 1'b0;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      sym_ff        <= sym_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule

`default_nettype wire

/* rtl/core/morse_lut.sv */
// Character lookup: case folding, table lookup and expansion into a row of
// 2-bit symbols, first element in the low bits. Uses morse_pkg.
`default_nettype none

module morse_lut (
   input  wire logic [7:0]                                              character,
   output logic [morse_pkg::LenWidth-1:0]                               len,
   output logic [morse_pkg::MaxElems*morse_pkg::SymWidth-1:0]           syms
);

   logic [7:0]          folded;
   morse_pkg::code_type code;
   logic [2:0]          idx [morse_pkg::MaxElems];

   always_comb begin
      if (character >= "a" && character <= "z") begin
         folded = character - 8'd32;
      end else begin
         folded = character;
      end
   end

   assign code = morse_pkg::code_lookup(folded);
   assign len  = code.len;

   always_comb begin
      syms = '0;
      for (int i = 0; i < morse_pkg::MaxElems; i++) begin
         idx[i] = 3'(code.len - 3'(i) - 3'd1);
         case (code.kind)
            morse_pkg::KIND_SPACE: begin
               syms[i*2 +: 2] = (i == 0) ? morse_pkg::SYM_GAP : morse_pkg::SYM_DOT;
            end
            morse_pkg::KIND_UNKNOWN: begin
               syms[i*2 +: 2] = (i == 1) ? morse_pkg::SYM_DOT : morse_pkg::SYM_GAP;
            end
            default: begin
               if (3'(i) < code.len && code.pat[idx[i]]) begin
                  syms[i*2 +: 2] = morse_pkg::SYM_DASH;
               end else begin
                  syms[i*2 +: 2] = morse_pkg::SYM_DOT;
               end
            end
         endcase
      end
   end

endmodule

`default_nettype wire
